// ----- src/tso_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package tso_pkg;

   typedef enum logic [1:0] {
      SHAPE_NONE   = 2'd0,
      SHAPE_SMALL  = 2'd1,
      SHAPE_LARGE  = 2'd2,
      SHAPE_SQUARE = 2'd3
   } shape_type;

   localparam int CSR_INDEX_W = 2;
   localparam logic [CSR_INDEX_W-1:0] CSR_SMALL_RADIUS = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_LARGE_RADIUS = 2'd1;

   localparam int RADIUS_W = 9;
   localparam int RSUM_W   = RADIUS_W + 1;
   localparam int DIFF_W   = 11;
   localparam int SQ_W     = 2 * DIFF_W;
   localparam int DIST_W   = SQ_W + 1;

   localparam int HALF_TILE = 128;
   localparam int ONE_TILE  = 256;
   localparam int FAR_LIMIT = 1024;

   localparam logic [RADIUS_W-1:0] SMALL_RADIUS_RESET = 9'd64;
   localparam logic [RADIUS_W-1:0] LARGE_RADIUS_RESET = 9'd128;

   typedef struct packed {
      logic                     decided;
      logic                     hit;
      logic signed [DIFF_W-1:0] dx;
      logic signed [DIFF_W-1:0] dy;
      logic [RSUM_W-1:0]        rsum;
   } prep_type;

endpackage

`default_nettype wire

// ----- src/tso_prep.sv -----
`timescale 1ns / 1ps
`default_nettype none

module tso_prep
   import tso_pkg::*;
#(
   parameter int POS_BITS = 16
) (
   input  shape_type             shape_a,
   input  logic [POS_BITS-1:0]   pos_a_x,
   input  logic [POS_BITS-1:0]   pos_a_y,
   input  shape_type             shape_b,
   input  logic [POS_BITS-1:0]   pos_b_x,
   input  logic [POS_BITS-1:0]   pos_b_y,
   input  logic [RADIUS_W-1:0]   small_radius,
   input  logic [RADIUS_W-1:0]   large_radius,
   output prep_type              prep
);

   localparam int W = (POS_BITS + 2 > 12) ? POS_BITS + 2 : 12;
   localparam logic signed [W-1:0] HALF_S = W'(HALF_TILE);
   localparam logic signed [W-1:0] ONE_S  = W'(ONE_TILE);
   localparam logic signed [W-1:0] FAR_S  = W'(FAR_LIMIT);

   logic signed [W-1:0] ax, ay, bx, by;
   logic signed [W-1:0] dx_cc, dy_cc;
   logic signed [W-1:0] cx, cy, lo_x, lo_y, hi_x, hi_y, nx, ny;
   logic signed [W-1:0] dx_cs, dy_cs, dx_sel, dy_sel;
   logic                a_is_circle, any_none, is_ss, is_cs;
   logic                in_box, far, ss_hit;
   logic [RADIUS_W-1:0] ra, rb, rc;

   assign ax = W'(pos_a_x);
   assign ay = W'(pos_a_y);
   assign bx = W'(pos_b_x);
   assign by = W'(pos_b_y);

   assign ra = (shape_a == SHAPE_SMALL) ? small_radius : large_radius;
   assign rb = (shape_b == SHAPE_SMALL) ? small_radius : large_radius;

   assign any_none    = (shape_a == SHAPE_NONE) || (shape_b == SHAPE_NONE);
   assign is_ss       = (shape_a == SHAPE_SQUARE) && (shape_b == SHAPE_SQUARE);
   assign is_cs       = (shape_a == SHAPE_SQUARE) != (shape_b == SHAPE_SQUARE);
   assign a_is_circle = (shape_b == SHAPE_SQUARE);

   assign dx_cc = ax - bx;
   assign dy_cc = ay - by;

   // The circle center sits half a tile in from its position.
   assign cx   = (a_is_circle ? ax : bx) + HALF_S;
   assign cy   = (a_is_circle ? ay : by) + HALF_S;
   assign lo_x = a_is_circle ? bx : ax;
   assign lo_y = a_is_circle ? by : ay;
   assign hi_x = lo_x + ONE_S;
   assign hi_y = lo_y + ONE_S;
   assign rc   = a_is_circle ? ra : rb;

   assign nx = (cx < lo_x) ? lo_x : ((cx > hi_x) ? hi_x : cx);
   assign ny = (cy < lo_y) ? lo_y : ((cy > hi_y) ? hi_y : cy);

   assign dx_cs = cx - nx;
   assign dy_cs = cy - ny;

   assign in_box = (cx >= lo_x) && (cx <= hi_x) && (cy >= lo_y) && (cy <= hi_y);

   assign dx_sel = is_cs ? dx_cs : dx_cc;
   assign dy_sel = is_cs ? dy_cs : dy_cc;

   assign far = (dx_sel >= FAR_S) || (dx_sel <= -FAR_S) ||
                (dy_sel >= FAR_S) || (dy_sel <= -FAR_S);

   assign ss_hit = (dx_cc >= -ONE_S) && (dx_cc <= ONE_S) &&
                   (dy_cc >= -ONE_S) && (dy_cc <= ONE_S);

   always_comb begin
      prep.dx   = dx_sel[DIFF_W-1:0];
      prep.dy   = dy_sel[DIFF_W-1:0];
      prep.rsum = is_cs ? RSUM_W'(rc) : (RSUM_W'(ra) + RSUM_W'(rb));
      priority if (any_none) begin
         prep.decided = 1'b1;
         prep.hit     = 1'b0;
      end else if (is_ss) begin
         prep.decided = 1'b1;
         prep.hit     = ss_hit;
      end else if (is_cs && in_box) begin
         prep.decided = 1'b1;
         prep.hit     = 1'b1;
      end else if (far) begin
         prep.decided = 1'b1;
         prep.hit     = 1'b0;
      end else begin
         prep.decided = 1'b0;
         prep.hit     = 1'b0;
      end
   end

endmodule

`default_nettype wire

// ----- src/tile_shape_overlap_test.sv -----
// A request accepted at a clock edge passes through the input, distance and result
// registers in that order before its result shows on rsp_valid and rsp_overlap.
// Throughput: one request per cycle; busy is always low, as the pipeline of
// input, distance and result registers never stalls and the receiver cannot either.
// Reset is synchronous and active high; it empties the pipeline and returns
// both radius registers to their default values.
`timescale 1ns / 1ps
`default_nettype none

module tile_shape_overlap_test
   import tso_pkg::*;
#(
   parameter int POS_BITS = 16
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   start,
   output logic                   busy,
   input  logic [1:0]             req_shape_a,
   input  logic [POS_BITS-1:0]    req_pos_a_x,
   input  logic [POS_BITS-1:0]    req_pos_a_y,
   input  logic [1:0]             req_shape_b,
   input  logic [POS_BITS-1:0]    req_pos_b_x,
   input  logic [POS_BITS-1:0]    req_pos_b_y,
   output logic                   rsp_valid,
   output logic                   rsp_overlap,
   input  logic                   csr_we,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [RADIUS_W-1:0]    csr_wdata
);

   logic [RADIUS_W-1:0] small_radius_ff, large_radius_ff;

   logic                s0_valid_ff;
   shape_type           s0_shape_a_ff, s0_shape_b_ff;
   logic [POS_BITS-1:0] s0_ax_ff, s0_ay_ff, s0_bx_ff, s0_by_ff;

   prep_type            prep_in, prep_ff;
   logic                s1_valid_ff;

   logic signed [SQ_W-1:0] dx_sq, dy_sq;
   logic [2*RSUM_W-1:0]    reach_sq;
   logic [DIST_W-1:0]      dist_sq;
   logic                   overlap_in, rsp_overlap_ff, rsp_valid_ff;
   logic                   accept;

   assign busy   = 1'b0;
   assign accept = start && !busy;

   always_ff @(posedge clock) begin
      if (reset) begin
         small_radius_ff <= SMALL_RADIUS_RESET;
         large_radius_ff <= LARGE_RADIUS_RESET;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_SMALL_RADIUS: small_radius_ff <= csr_wdata;
            CSR_LARGE_RADIUS: large_radius_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s0_valid_ff  <= 1'b0;
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s0_valid_ff  <= accept;
         s1_valid_ff  <= s0_valid_ff;
         rsp_valid_ff <= s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s0_shape_a_ff <= shape_type'(req_shape_a);
         s0_shape_b_ff <= shape_type'(req_shape_b);
         s0_ax_ff      <= req_pos_a_x;
         s0_ay_ff      <= req_pos_a_y;
         s0_bx_ff      <= req_pos_b_x;
         s0_by_ff      <= req_pos_b_y;
      end
      prep_ff        <= prep_in;
      rsp_overlap_ff <= overlap_in;
   end

   tso_prep #(
      .POS_BITS(POS_BITS)
   ) u_prep (
      .shape_a      (s0_shape_a_ff),
      .pos_a_x      (s0_ax_ff),
      .pos_a_y      (s0_ay_ff),
      .shape_b      (s0_shape_b_ff),
      .pos_b_x      (s0_bx_ff),
      .pos_b_y      (s0_by_ff),
      .small_radius (small_radius_ff),
      .large_radius (large_radius_ff),
      .prep         (prep_in)
   );

   assign dx_sq    = prep_ff.dx * prep_ff.dx;
   assign dy_sq    = prep_ff.dy * prep_ff.dy;
   assign reach_sq = prep_ff.rsum * prep_ff.rsum;
   assign dist_sq  = DIST_W'(unsigned'(dx_sq)) + DIST_W'(unsigned'(dy_sq));

   assign overlap_in = prep_ff.decided ? prep_ff.hit : (dist_sq < DIST_W'(reach_sq));

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_overlap = rsp_overlap_ff;

endmodule

`default_nettype wire

// ----- src/tso_checker.sv -----
`timescale 1ns / 1ps
`default_nettype none

module tso_checker
   import tso_pkg::*;
#(
   parameter int POS_BITS = 16
) (
   input logic                   clock,
   input logic                   reset,
   input logic                   start,
   input logic                   busy,
   input logic [1:0]             req_shape_a,
   input logic [POS_BITS-1:0]    req_pos_a_x,
   input logic [POS_BITS-1:0]    req_pos_a_y,
   input logic [1:0]             req_shape_b,
   input logic [POS_BITS-1:0]    req_pos_b_x,
   input logic [POS_BITS-1:0]    req_pos_b_y,
   input logic                   rsp_valid,
   input logic                   rsp_overlap
);

   logic accept;
   assign accept = start && !busy;

   // The block never refuses a request.
   a_never_busy: assert property (@(posedge clock) disable iff (reset) !busy)
      else $error("busy raised");

   a_request_answered: assert property (@(posedge clock) disable iff (reset)
      (accept && !reset) ##1 !reset ##1 !reset |=> rsp_valid)
      else $error("accepted request produced no response");

   a_no_spurious_response: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(accept, 3))
      else $error("response without a request");

   a_none_misses: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && $past(req_shape_a == SHAPE_NONE || req_shape_b == SHAPE_NONE, 3)
      |-> !rsp_overlap)
      else $error("overlap reported for an object without shape");

   a_same_square_hits: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && $past(req_shape_a == SHAPE_SQUARE && req_shape_b == SHAPE_SQUARE &&
                         req_pos_a_x == req_pos_b_x && req_pos_a_y == req_pos_b_y, 3)
      |-> rsp_overlap)
      else $error("coincident squares not reported as overlapping");

endmodule

bind tile_shape_overlap_test tso_checker #(.POS_BITS(POS_BITS)) u_tso_checker (.*);

`default_nettype wire

// ----- sim/tb_top.sv -----
`timescale 1ns / 1ps

module tb_top;
   import tso_pkg::*;

   localparam int POS_BITS = 16;
   localparam int WATCHDOG_LIMIT = 2000;
   localparam int MAX_REPORTS = 10;
   localparam logic [CSR_INDEX_W-1:0] CSR_SPARE_2 = 2'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_SPARE_3 = 2'd3;

   typedef logic [POS_BITS-1:0] pos_type;

   typedef struct packed {
      bit                     is_csr;
      logic [CSR_INDEX_W-1:0] csr_idx;
      logic [RADIUS_W-1:0]    csr_val;
      shape_type              sa;
      pos_type                ax;
      pos_type                ay;
      shape_type              sb;
      pos_type                bx;
      pos_type                by;
      bit                     fixed;
      bit                     want;
   } pair_row_type;

   typedef struct packed {
      bit          want;
      logic [31:0] seq;
   } overlap_expect_type;

   logic                   clock;
   logic                   reset;
   logic                   start;
   logic                   busy;
   logic [1:0]             req_shape_a;
   pos_type                req_pos_a_x;
   pos_type                req_pos_a_y;
   logic [1:0]             req_shape_b;
   pos_type                req_pos_b_x;
   pos_type                req_pos_b_y;
   logic                   rsp_valid;
   logic                   rsp_overlap;
   logic                   csr_we;
   logic [CSR_INDEX_W-1:0] csr_index;
   logic [RADIUS_W-1:0]    csr_wdata;

   bit                     req_fixed;
   bit                     req_fixed_val;
   logic [RADIUS_W-1:0]    small_r;
   logic [RADIUS_W-1:0]    large_r;
   overlap_expect_type     pending_overlaps[$];
   pair_row_type           directed_rows[$];
   int                     idle_pct;
   int                     requests_taken = 0;
   int                     overlaps_seen = 0;
   int                     mismatches = 0;
   int                     radius_settings;
   int                     quiet_cycles = 0;

   tile_shape_overlap_test #(.POS_BITS(POS_BITS)) dut (
      .clock       (clock),
      .reset       (reset),
      .start       (start),
      .busy        (busy),
      .req_shape_a (req_shape_a),
      .req_pos_a_x (req_pos_a_x),
      .req_pos_a_y (req_pos_a_y),
      .req_shape_b (req_shape_b),
      .req_pos_b_x (req_pos_b_x),
      .req_pos_b_y (req_pos_b_y),
      .rsp_valid   (rsp_valid),
      .rsp_overlap (rsp_overlap),
      .csr_we      (csr_we),
      .csr_index   (csr_index),
      .csr_wdata   (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   function automatic longint radius_for(shape_type s);
      return (s == SHAPE_SMALL) ? longint'(small_r) : longint'(large_r);
   endfunction

   function automatic bit beyond_reach(longint dx, longint dy);
      return dx >= FAR_LIMIT || dx <= -FAR_LIMIT || dy >= FAR_LIMIT || dy <= -FAR_LIMIT;
   endfunction

   function automatic bit circle_meets_square(longint cx, longint cy, longint r,
                                              longint sx, longint sy);
      longint nx, ny, dx, dy;
      cx = cx + HALF_TILE;
      cy = cy + HALF_TILE;
      if (cx >= sx && cy >= sy && cx <= sx + ONE_TILE && cy <= sy + ONE_TILE) return 1'b1;
      nx = (cx < sx) ? sx : ((cx > sx + ONE_TILE) ? sx + ONE_TILE : cx);
      ny = (cy < sy) ? sy : ((cy > sy + ONE_TILE) ? sy + ONE_TILE : cy);
      dx = cx - nx;
      dy = cy - ny;
      if (beyond_reach(dx, dy)) return 1'b0;
      return dx * dx + dy * dy < r * r;
   endfunction

   function automatic bit predict_overlap(shape_type sa, pos_type pax, pos_type pay,
                                          shape_type sb, pos_type pbx, pos_type pby);
      longint ax, ay, bx, by, dx, dy, rsum;
      ax = longint'(pax);
      ay = longint'(pay);
      bx = longint'(pbx);
      by = longint'(pby);
      dx = ax - bx;
      dy = ay - by;
      if (sa == SHAPE_NONE || sb == SHAPE_NONE) return 1'b0;
      if (sa != SHAPE_SQUARE && sb != SHAPE_SQUARE) begin
         rsum = radius_for(sa) + radius_for(sb);
         if (beyond_reach(dx, dy)) return 1'b0;
         return dx * dx + dy * dy < rsum * rsum;
      end
      if (sa != SHAPE_SQUARE) return circle_meets_square(ax, ay, radius_for(sa), bx, by);
      if (sb != SHAPE_SQUARE) return circle_meets_square(bx, by, radius_for(sb), ax, ay);
      return dx >= -ONE_TILE && dx <= ONE_TILE && dy >= -ONE_TILE && dy <= ONE_TILE;
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         small_r <= SMALL_RADIUS_RESET;
         large_r <= LARGE_RADIUS_RESET;
      end else begin
         if (csr_we) begin
            if (csr_index == CSR_SMALL_RADIUS) begin
               small_r <= csr_wdata;
            end else if (csr_index == CSR_LARGE_RADIUS) begin
               large_r <= csr_wdata;
            end
         end
         if (rsp_valid) begin
            if (pending_overlaps.size() == 0) begin
               mismatches++;
               if (mismatches <= MAX_REPORTS)
                  $display("result with no request pending: overlap %0b", rsp_overlap);
            end else begin
               overlap_expect_type e;
               e = pending_overlaps.pop_front();
               if (rsp_overlap !== e.want) begin
                  mismatches++;
                  if (mismatches <= MAX_REPORTS)
                     $display("request %0d: overlap expected %0b, got %0b",
                              e.seq, e.want, rsp_overlap);
               end
            end
            if (rsp_overlap === 1'b1) overlaps_seen++;
         end
         if (start && !busy) begin
            overlap_expect_type e;
            e.seq = requests_taken;
            e.want = req_fixed ? req_fixed_val
                               : predict_overlap(shape_type'(req_shape_a), req_pos_a_x,
                                                 req_pos_a_y, shape_type'(req_shape_b),
                                                 req_pos_b_x, req_pos_b_y);
            pending_overlaps = {pending_overlaps, e};
            requests_taken++;
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_valid) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("end of test: mismatches");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   task automatic send_pair(pair_row_type r);
      @(negedge clock);
      while ($urandom_range(0, 99) < idle_pct) begin
         start <= 1'b0;
         @(negedge clock);
      end
      start         <= 1'b1;
      req_shape_a   <= r.sa;
      req_pos_a_x   <= r.ax;
      req_pos_a_y   <= r.ay;
      req_shape_b   <= r.sb;
      req_pos_b_x   <= r.bx;
      req_pos_b_y   <= r.by;
      req_fixed     <= r.fixed;
      req_fixed_val <= r.want;
      @(posedge clock);
      while (busy) @(posedge clock);
   endtask

   task automatic drain_pipeline();
      @(negedge clock);
      start <= 1'b0;
      while (pending_overlaps.size() != 0) @(negedge clock);
      repeat (2) @(negedge clock);
   endtask

   task automatic write_csr(logic [CSR_INDEX_W-1:0] idx, logic [RADIUS_W-1:0] val);
      @(negedge clock);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(negedge clock);
      csr_we    <= 1'b0;
   endtask

   task automatic add_pair(shape_type sa, pos_type ax, pos_type ay, shape_type sb,
                           pos_type bx, pos_type by, bit fixed, bit want);
      pair_row_type r;
      r = '0;
      r.sa = sa;
      r.ax = ax;
      r.ay = ay;
      r.sb = sb;
      r.bx = bx;
      r.by = by;
      r.fixed = fixed;
      r.want = want;
      directed_rows = {directed_rows, r};
   endtask

   task automatic add_csr(logic [CSR_INDEX_W-1:0] idx, logic [RADIUS_W-1:0] val);
      pair_row_type r;
      r = '0;
      r.is_csr = 1'b1;
      r.csr_idx = idx;
      r.csr_val = val;
      directed_rows = {directed_rows, r};
   endtask

   function automatic shape_type random_shape();
      int v;
      v = $urandom_range(0, 15);
      return (v == 0) ? SHAPE_NONE : shape_type'(1 + v % 3);
   endfunction

   function automatic pair_row_type random_pair(int sr, int lr);
      pair_row_type r;
      int mode, reach, ox, oy, t;
      r = '0;
      r.sa = random_shape();
      r.sb = random_shape();
      r.bx = pos_type'($urandom);
      r.by = pos_type'($urandom);
      mode = $urandom_range(0, 99);
      if (mode < 10) begin
         r.ax = pos_type'($urandom);
         r.ay = pos_type'($urandom);
      end else begin
         if (mode < 70) begin
            ox = $urandom_range(0, 1400) - 700;
            oy = $urandom_range(0, 1400) - 700;
         end else begin
            case ($urandom_range(0, 3))
               0: reach = ONE_TILE;
               1: reach = sr + lr;
               2: reach = lr + HALF_TILE;
               default: reach = sr + HALF_TILE + ONE_TILE;
            endcase
            ox = reach + $urandom_range(0, 2) - 1;
            if ($urandom_range(0, 1)) ox = -ox;
            oy = $urandom_range(0, 6) - 3;
            if ($urandom_range(0, 1)) begin
               t = ox;
               ox = oy;
               oy = t;
            end
         end
         r.ax = pos_type'(int'(r.bx) + ox);
         r.ay = pos_type'(int'(r.by) + oy);
      end
      return r;
   endfunction

   initial begin
      int sr, lr;
      pair_row_type r;
      reset = 1'b1;
      start = 1'b0;
      req_shape_a = SHAPE_NONE;
      req_pos_a_x = '0;
      req_pos_a_y = '0;
      req_shape_b = SHAPE_NONE;
      req_pos_b_x = '0;
      req_pos_b_y = '0;
      csr_we = 1'b0;
      csr_index = CSR_SMALL_RADIUS;
      csr_wdata = '0;
      req_fixed = 1'b0;
      req_fixed_val = 1'b0;
      idle_pct = 38;
      radius_settings = 1;

      add_pair(SHAPE_NONE, 0, 0, SHAPE_NONE, 0, 0, 1, 0);
      add_pair(SHAPE_NONE, 0, 0, SHAPE_SQUARE, 0, 0, 1, 0);
      add_pair(SHAPE_SMALL, 0, 0, SHAPE_NONE, 0, 0, 1, 0);
      add_pair(SHAPE_SMALL, 100, 100, SHAPE_SMALL, 100, 100, 1, 1);
      add_pair(SHAPE_LARGE, 0, 0, SHAPE_LARGE, 16'hFFFF, 16'hFFFF, 1, 0);
      add_pair(SHAPE_SQUARE, 0, 0, SHAPE_SQUARE, 0, 0, 1, 1);
      add_pair(SHAPE_SQUARE, 256, 0, SHAPE_SQUARE, 0, 0, 1, 1);
      add_pair(SHAPE_SQUARE, 257, 0, SHAPE_SQUARE, 0, 0, 1, 0);
      add_pair(SHAPE_SQUARE, 16'hFFFF, 16'hFFFF, SHAPE_SQUARE, 16'hFEFF, 16'hFEFF, 1, 1);
      add_pair(SHAPE_SMALL, 0, 0, SHAPE_SQUARE, 0, 0, 1, 1);
      add_pair(SHAPE_SQUARE, 0, 0, SHAPE_LARGE, 300, 0, 0, 0);
      add_pair(SHAPE_SMALL, 0, 0, SHAPE_SMALL, 128, 0, 1, 0);
      add_pair(SHAPE_SMALL, 0, 0, SHAPE_SMALL, 127, 0, 0, 0);
      add_pair(SHAPE_LARGE, 300, 300, SHAPE_SQUARE, 0, 0, 0, 0);
      add_pair(SHAPE_LARGE, 2000, 0, SHAPE_SQUARE, 0, 0, 1, 0);
      add_pair(SHAPE_SMALL, 16'hFFFF, 0, SHAPE_LARGE, 0, 16'hFFFF, 0, 0);
      add_csr(CSR_SMALL_RADIUS, 9'd0);
      add_csr(CSR_LARGE_RADIUS, 9'd0);
      add_pair(SHAPE_SMALL, 5, 5, SHAPE_SMALL, 5, 5, 1, 0);
      add_pair(SHAPE_SQUARE, 0, 0, SHAPE_SMALL, 128, 0, 1, 1);
      add_pair(SHAPE_LARGE, 0, 0, SHAPE_SQUARE, 200, 0, 0, 0);
      add_csr(CSR_SMALL_RADIUS, 9'd511);
      add_csr(CSR_LARGE_RADIUS, 9'd511);
      add_csr(CSR_SPARE_2, 9'h155);
      add_csr(CSR_SPARE_3, 9'h0AA);
      add_pair(SHAPE_LARGE, 0, 0, SHAPE_LARGE, 1021, 0, 0, 0);
      add_pair(SHAPE_SMALL, 0, 0, SHAPE_LARGE, 1023, 0, 0, 0);
      add_pair(SHAPE_LARGE, 1024, 0, SHAPE_LARGE, 0, 0, 1, 0);
      add_pair(SHAPE_SMALL, 0, 0, SHAPE_SQUARE, 800, 0, 0, 0);

      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      foreach (directed_rows[i]) begin
         if (directed_rows[i].is_csr) begin
            drain_pipeline();
            write_csr(directed_rows[i].csr_idx, directed_rows[i].csr_val);
            radius_settings++;
         end else begin
            send_pair(directed_rows[i]);
         end
      end

      for (int phase = 0; phase < 6; phase++) begin
         case (phase)
            0: begin sr = int'(SMALL_RADIUS_RESET); lr = int'(LARGE_RADIUS_RESET); end
            1: begin sr = 0; lr = 0; end
            2: begin sr = 511; lr = 511; end
            3: begin sr = 1; lr = 510; end
            default: begin sr = $urandom_range(0, 511); lr = $urandom_range(0, 511); end
         endcase
         drain_pipeline();
         write_csr(CSR_SMALL_RADIUS, RADIUS_W'(sr));
         write_csr(CSR_LARGE_RADIUS, RADIUS_W'(lr));
         radius_settings++;
         idle_pct = (phase == 3) ? 0 : 38;
         repeat (255) begin
            r = random_pair(sr, lr);
            send_pair(r);
         end
      end

      drain_pipeline();
      repeat (8) @(posedge clock);
      $display("Checked %0d requests, %0d of them overlapping, across %0d radius settings.",
               requests_taken, overlaps_seen, radius_settings);
      $display("Mismatches found: %0d.", mismatches);
      if (mismatches == 0 && pending_overlaps.size() == 0) begin
         $display("end of test: clean");
      end else begin
         $display("end of test: mismatches");
      end
      $finish;
   end

endmodule
